### src/pi_speed_loop_dynamic_gain_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the PI speed loop
// Short forms for clocked, reset-qualified implication properties.
// ---------------------------------------------------------------------------
`ifndef PI_SPEED_LOOP_DYNAMIC_GAIN_ASSERT_SVH
`define PI_SPEED_LOOP_DYNAMIC_GAIN_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSLG_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pslg assertion failed: same-cycle check");

// Consequent must hold in the cycle after the antecedent.
`define PSLG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pslg assertion failed: next-cycle check");

`endif

### src/pslg_pkg.sv
// ---------------------------------------------------------------------------
// pslg_pkg
// Shared widths, register indexes, reset values and control structs.
// ---------------------------------------------------------------------------
package pslg_pkg;

  // Field widths.
  localparam int unsigned SpeedW = 24;
  localparam int unsigned ErrW   = SpeedW + 1;
  localparam int unsigned GainW  = 16;
  localparam int unsigned FgeW   = 23;
  localparam int unsigned PerW   = 16;
  localparam int unsigned DutyW  = 16;
  localparam int unsigned IntegW = 40;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 23;

  // The interpolated gain step is below 2^16, so the divider needs 16 steps.
  localparam int unsigned DivSteps = GainW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Reset values of the configuration registers.
  localparam logic [GainW-1:0] BaseGainRst = 16'd1280;
  localparam logic [GainW-1:0] MaxGainRst  = 16'd25600;
  localparam logic [FgeW-1:0]  FgeRst      = 23'd12800;
  localparam logic [GainW-1:0] IntGainRst  = 16'd2560;
  localparam logic [PerW-1:0]  PeriodRst   = 16'd655;
  localparam logic [DutyW-1:0] DutyLowRst  = 16'hE4A8;  // -7000
  localparam logic [DutyW-1:0] DutyHighRst = 16'h1B58;  // +7000

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_BASE_GAIN       = 3'd0,
    REG_MAX_GAIN        = 3'd1,
    REG_FULL_GAIN_ERROR = 3'd2,
    REG_INTEGRAL_GAIN   = 3'd3,
    REG_SAMPLE_PERIOD   = 3'd4,
    REG_DUTY_LOW        = 3'd5,
    REG_DUTY_HIGH       = 3'd6
  } pslg_reg_e;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;      // capture the speeds of a new item
    logic prep;      // gain select, divider set-up, Ki*T product
    logic div_step;  // one restoring division step
    logic gain;      // form the gain and the integral product
    logic pmul;      // proportional product and integral increment
    logic tent;      // saturated tentative integral
    logic test;      // anti-windup test and commit
    logic sum;       // duty sum from the committed integral
    logic emit;      // clamp, truncate and load the result register
  } pslg_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic div_last;  // current division step is the final one
  } pslg_st_t;

endpackage

### src/pslg_in_if.sv
// ---------------------------------------------------------------------------
// pslg_in_if
// Input channel: target and measured speed, valid/ready handshake.
// ---------------------------------------------------------------------------
interface pslg_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pslg_pkg::SpeedW-1:0]    target_speed;
  logic signed [pslg_pkg::SpeedW-1:0]    measured_speed;

  modport source (output valid, output target_speed, output measured_speed, input ready);
  modport sink   (input valid, input target_speed, input measured_speed, output ready);
endinterface

### src/pslg_out_if.sv
// ---------------------------------------------------------------------------
// pslg_out_if
// Output channel: clamped duty, valid/ready handshake.
// ---------------------------------------------------------------------------
interface pslg_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pslg_pkg::DutyW-1:0]     duty;

  modport source (output valid, output duty, input ready);
  modport sink   (input valid, input duty, output ready);
endinterface

### src/pslg_ctrl.sv
// ---------------------------------------------------------------------------
// pslg_ctrl
// Sequencer: steps one item through the datapath and owns the handshakes.
// ---------------------------------------------------------------------------
module pslg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  pslg_pkg::pslg_st_t  st_i,
  output pslg_pkg::pslg_cmd_t cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_PREP = 9'b000000010,
    S_DIV  = 9'b000000100,
    S_GAIN = 9'b000001000,
    S_PMUL = 9'b000010000,
    S_TENT = 9'b000100000,
    S_TEST = 9'b001000000,
    S_SUM  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // The result register can take a new item once it is empty or being drained.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (st_i.div_last) begin
          state_d = S_GAIN;
        end
      end
      S_GAIN: begin
        cmd_o.gain = 1'b1;
        state_d    = S_PMUL;
      end
      S_PMUL: begin
        cmd_o.pmul = 1'b1;
        state_d    = S_TENT;
      end
      S_TENT: begin
        cmd_o.tent = 1'b1;
        state_d    = S_TEST;
      end
      S_TEST: begin
        cmd_o.test = 1'b1;
        state_d    = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid flag follows loads and drains of the result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### src/pslg_dp.sv
// ---------------------------------------------------------------------------
// pslg_dp
// Datapath: configuration registers, gain divider, products, integral and
// duty clamp.
// ---------------------------------------------------------------------------
module pslg_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pslg_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [pslg_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic signed [pslg_pkg::SpeedW-1:0]  target_speed_i,
  input  logic signed [pslg_pkg::SpeedW-1:0]  measured_speed_i,
  input  pslg_pkg::pslg_cmd_t                 cmd_i,
  output pslg_pkg::pslg_st_t                  st_o,
  output logic signed [pslg_pkg::DutyW-1:0]   duty_o
);

  localparam int unsigned ErrW   = pslg_pkg::ErrW;
  localparam int unsigned GainW  = pslg_pkg::GainW;
  localparam int unsigned FgeW   = pslg_pkg::FgeW;
  localparam int unsigned PerW   = pslg_pkg::PerW;
  localparam int unsigned DutyW  = pslg_pkg::DutyW;
  localparam int unsigned IntegW = pslg_pkg::IntegW;
  localparam int unsigned KpW    = GainW + PerW;          // Ki*T, unsigned
  localparam int unsigned IprodW = KpW + 1 + ErrW;        // Ki*T*e, signed
  localparam int unsigned IncW   = IprodW - 24;           // after /2^24
  localparam int unsigned PW     = GainW + 1 + ErrW;      // g*e, signed
  localparam int unsigned DW     = IntegW + 9;            // p + integral*256
  localparam int unsigned DivW   = GainW + FgeW;          // |diff|*|e|

  // Configuration registers.
  logic [GainW-1:0]        base_q, max_q, ki_q;
  logic [FgeW-1:0]         fge_q;
  logic [PerW-1:0]         per_q;
  logic signed [DutyW-1:0] dlo_q, dhi_q;

  // Item state.
  logic signed [ErrW-1:0]   err_q;
  logic [ErrW-1:0]          abs_q;
  logic                     sel_max_q, diff_neg_q;
  logic [FgeW-1:0]          rem_q;
  logic [GainW-1:0]         quo_q;
  logic [pslg_pkg::DivCntW-1:0] cnt_q;
  logic [KpW-1:0]           kp_q;
  logic [GainW-1:0]         gain_q;
  logic signed [IprodW-1:0] iprod_q;
  logic signed [PW-1:0]     p_q;
  logic signed [IncW-1:0]   inc_q;
  logic signed [IntegW-1:0] tent_q, integ_q;
  logic signed [DW-1:0]     d2_q;
  logic signed [DutyW-1:0]  duty_q;

  // Combinational intermediates.
  logic signed [ErrW-1:0]   err_new;
  logic signed [GainW:0]    diff;
  logic [GainW:0]           diff_mag;
  logic [DivW-1:0]          dividend;
  logic [FgeW:0]            trial_num, trial;
  logic                     trial_ge;
  logic [GainW:0]           gain_sum;
  logic signed [IprodW-1:0] iprod_adj;
  logic signed [IntegW:0]   tent_sum;
  logic signed [IntegW-1:0] tent_sat;
  logic signed [DW-1:0]     d_test, d2_new, hi_ext, lo_ext, d2_adj;
  logic                     err_pos, err_neg, commit;
  logic signed [DutyW-1:0]  duty_new;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= pslg_pkg::BaseGainRst;
      max_q  <= pslg_pkg::MaxGainRst;
      fge_q  <= pslg_pkg::FgeRst;
      ki_q   <= pslg_pkg::IntGainRst;
      per_q  <= pslg_pkg::PeriodRst;
      dlo_q  <= pslg_pkg::DutyLowRst;
      dhi_q  <= pslg_pkg::DutyHighRst;
    end else if (cfg_we_i) begin
      unique case (pslg_pkg::pslg_reg_e'(cfg_idx_i))
        pslg_pkg::REG_BASE_GAIN:       base_q <= cfg_data_i[GainW-1:0];
        pslg_pkg::REG_MAX_GAIN:        max_q  <= cfg_data_i[GainW-1:0];
        pslg_pkg::REG_FULL_GAIN_ERROR: fge_q  <= cfg_data_i[FgeW-1:0];
        pslg_pkg::REG_INTEGRAL_GAIN:   ki_q   <= cfg_data_i[GainW-1:0];
        pslg_pkg::REG_SAMPLE_PERIOD:   per_q  <= cfg_data_i[PerW-1:0];
        pslg_pkg::REG_DUTY_LOW:        dlo_q  <= $signed(cfg_data_i[DutyW-1:0]);
        pslg_pkg::REG_DUTY_HIGH:       dhi_q  <= $signed(cfg_data_i[DutyW-1:0]);
        default: ;
      endcase
    end
  end

  // Error of the incoming item.
  assign err_new = $signed({target_speed_i[pslg_pkg::SpeedW-1], target_speed_i})
                 - $signed({measured_speed_i[pslg_pkg::SpeedW-1], measured_speed_i});

  // Gain slope magnitude and the dividend of the interpolation.
  assign diff     = $signed({1'b0, max_q}) - $signed({1'b0, base_q});
  assign diff_mag = diff[GainW] ? (~diff + (GainW+1)'(1)) : diff;
  assign dividend = DivW'(diff_mag[GainW-1:0]) * DivW'(abs_q[FgeW-1:0]);

  // One restoring division step: bring down the next dividend bit.
  assign trial_num = {rem_q, quo_q[GainW-1]};
  assign trial     = trial_num - {1'b0, fge_q};
  assign trial_ge  = (trial_num >= {1'b0, fge_q});
  assign st_o.div_last = (cnt_q == pslg_pkg::DivCntW'(pslg_pkg::DivSteps - 1));

  // Interpolated gain: base plus or minus the truncated quotient.
  assign gain_sum = diff_neg_q ? ({1'b0, base_q} - {1'b0, quo_q})
                               : ({1'b0, base_q} + {1'b0, quo_q});

  // Integral increment, truncated toward zero.
  assign iprod_adj = iprod_q + (iprod_q[IprodW-1] ? IprodW'((1 << 24) - 1) : IprodW'(0));

  // Tentative integral, saturated to the integral width.
  assign tent_sum = $signed({integ_q[IntegW-1], integ_q})
                  + $signed({{(IntegW + 1 - IncW){inc_q[IncW-1]}}, inc_q});
  always_comb begin
    if (tent_sum[IntegW] != tent_sum[IntegW-1]) begin
      tent_sat = tent_sum[IntegW] ? {1'b1, {(IntegW-1){1'b0}}}
                                  : {1'b0, {(IntegW-1){1'b1}}};
    end else begin
      tent_sat = tent_sum[IntegW-1:0];
    end
  end

  // Duty limits scaled to the Q.16 sum.
  assign hi_ext = $signed({{(DW-DutyW-16){dhi_q[DutyW-1]}}, dhi_q, 16'b0});
  assign lo_ext = $signed({{(DW-DutyW-16){dlo_q[DutyW-1]}}, dlo_q, 16'b0});
  assign err_pos = !err_q[ErrW-1] && (err_q != '0);
  assign err_neg = err_q[ErrW-1];

  // Anti-windup: keep the old integral when the tentative one drives past a limit or the period is zero.
  assign d_test = $signed({{(DW-PW){p_q[PW-1]}}, p_q}) + $signed({tent_q[IntegW-1], tent_q, 8'b0});
  assign commit = (per_q != '0) && !(((d_test > hi_ext) && err_pos) || ((d_test < lo_ext) && err_neg));

  assign d2_new = $signed({{(DW-PW){p_q[PW-1]}}, p_q}) + $signed({integ_q[IntegW-1], integ_q, 8'b0});

  // Clamp and truncate toward zero; a zero period gives zero duty.
  assign d2_adj = d2_q + (d2_q[DW-1] ? DW'(16'hFFFF) : DW'(0));
  always_comb begin
    if (per_q == '0) begin
      duty_new = '0;
    end else if (d2_q > hi_ext) begin
      duty_new = dhi_q;
    end else if (d2_q < lo_ext) begin
      duty_new = dlo_q;
    end else begin
      duty_new = d2_adj[DutyW+15:16];
    end
  end

  // Control state: integral and divider step count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      cnt_q   <= '0;
    end else begin
      if (cmd_i.test && commit) begin
        integ_q <= tent_q;
      end
      if (cmd_i.prep) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + pslg_pkg::DivCntW'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      err_q <= err_new;
      abs_q <= err_new[ErrW-1] ? ErrW'(-err_new) : ErrW'(err_new);
    end
    if (cmd_i.prep) begin
      sel_max_q  <= (fge_q == '0) || (abs_q >= {{(ErrW-FgeW){1'b0}}, fge_q});
      diff_neg_q <= diff[GainW];
      rem_q      <= dividend[DivW-1:GainW];
      quo_q      <= dividend[GainW-1:0];
      kp_q       <= KpW'(ki_q) * KpW'(per_q);
    end
    if (cmd_i.div_step) begin
      rem_q <= trial_ge ? trial[FgeW-1:0] : trial_num[FgeW-1:0];
      quo_q <= {quo_q[GainW-2:0], trial_ge};
    end
    if (cmd_i.gain) begin
      gain_q  <= sel_max_q ? max_q : gain_sum[GainW-1:0];
      iprod_q <= IprodW'($signed({1'b0, kp_q})) * IprodW'(err_q);
    end
    if (cmd_i.pmul) begin
      p_q   <= PW'($signed({1'b0, gain_q})) * PW'(err_q);
      inc_q <= iprod_adj[IprodW-1:24];
    end
    if (cmd_i.tent) begin
      tent_q <= tent_sat;
    end
    if (cmd_i.sum) begin
      d2_q <= d2_new;
    end
    if (cmd_i.emit) begin
      duty_q <= duty_new;
    end
  end

  assign duty_o = duty_q;

endmodule

### src/pi_speed_loop_dynamic_gain.sv
// ---------------------------------------------------------------------------
// pi_speed_loop_dynamic_gain
// Positional PI speed loop with error-dependent proportional gain and
// conditional-integration anti-windup.
// ---------------------------------------------------------------------------
//  Channel | Direction | Handshake        | Payload
//  in_ch   | sink      | valid/ready      | target_speed, measured_speed (Q15.8)
//  out_ch  | source    | valid/ready      | duty (signed integer)
//  cfg     | sink      | cfg_we_i strobe  | cfg_idx_i, cfg_data_i
//
// An item passes from acceptance through set-up, the restoring divider that
// interpolates the gain, the products, the integral update and the duty sum
// to the output register.
// A new item is taken while a finished result still waits in the output
// register; a stalled output holds the sequencer only at its final step.
// Reset clears the integral and loads the default register values.
// ---------------------------------------------------------------------------
`include "pi_speed_loop_dynamic_gain_assert.svh"

module pi_speed_loop_dynamic_gain (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pslg_in_if.sink                       in_ch,
  pslg_out_if.source                    out_ch,
  input  logic                          cfg_we_i,
  input  logic [pslg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pslg_pkg::CfgDataW-1:0] cfg_data_i
);

  pslg_pkg::pslg_cmd_t cmd;
  pslg_pkg::pslg_st_t  st;

  // Sequencer.
  pslg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  // Arithmetic and state.
  pslg_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .target_speed_i   (in_ch.target_speed),
    .measured_speed_i (in_ch.measured_speed),
    .cmd_i            (cmd),
    .st_o             (st),
    .duty_o           (out_ch.duty)
  );

  // The block is busy on the cycle after it takes an item.
  `PSLG_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_ch.valid && in_ch.ready, !in_ch.ready)
  // The sequencer issues at most one datapath command per cycle.
  `PSLG_ASSERT_IMPL(a_cmd_onehot, clk_i, rst_ni, 1'b1, $onehot0(cmd))
  // The last division step is followed by the gain step.
  `PSLG_ASSERT_NEXT(a_div_to_gain, clk_i, rst_ni, cmd.div_step && st.div_last, cmd.gain)
  // Loading the result register raises output valid.
  `PSLG_ASSERT_NEXT(a_emit_valid, clk_i, rst_ni, cmd.emit, out_ch.valid)

endmodule

### test/tb_pi_speed_loop_dynamic_gain.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the dynamic-gain PI speed loop
// Drives speed pairs through the valid/ready input channel under a series of
// register settings and checks every duty item against a cycle-free model of
// the gain interpolation, the conditional integration and the output clamp.
// ---------------------------------------------------------------------------
module tb_pi_speed_loop_dynamic_gain;
  import pslg_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpare = 3'd7;  // index with no register behind it
  localparam longint IntegHigh  = (longint'(1) <<< 39) - 1;
  localparam longint IntegLow   = -(longint'(1) <<< 39);
  localparam longint IncScale   = longint'(1) <<< 24;
  localparam longint DutyScale  = 65536;
  localparam int     HoldCycles = 300;
  localparam int     IdleLimit  = 2000;
  localparam int     DrainWait  = 40;

  // Expected duty values, worked out from the register copy and the integral.
  class pi_duty_tracker;
    logic [GainW-1:0]        base_gain;
    logic [GainW-1:0]        max_gain;
    logic [FgeW-1:0]         full_err;
    logic [GainW-1:0]        int_gain;
    logic [PerW-1:0]         period;
    logic signed [DutyW-1:0] duty_low;
    logic signed [DutyW-1:0] duty_high;
    longint                  integ;
    logic signed [DutyW-1:0] pending_duty[$];
    int                      mismatches;

    function new();
      base_gain  = BaseGainRst;
      max_gain   = MaxGainRst;
      full_err   = FgeRst;
      int_gain   = IntGainRst;
      period     = PeriodRst;
      duty_low   = DutyLowRst;
      duty_high  = DutyHighRst;
      integ      = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_BASE_GAIN:       base_gain = data[GainW-1:0];
        REG_MAX_GAIN:        max_gain  = data[GainW-1:0];
        REG_FULL_GAIN_ERROR: full_err  = data[FgeW-1:0];
        REG_INTEGRAL_GAIN:   int_gain  = data[GainW-1:0];
        REG_SAMPLE_PERIOD:   period    = data[PerW-1:0];
        REG_DUTY_LOW:        duty_low  = data[DutyW-1:0];
        REG_DUTY_HIGH:       duty_high = data[DutyW-1:0];
        default: ;
      endcase
    endfunction

    // Work out the duty for one accepted speed pair and queue it.
    function void note_item(logic signed [SpeedW-1:0] tgt, logic signed [SpeedW-1:0] meas);
      longint err, mag, gain, prop, step, trial, sum, hi, lo;
      logic signed [DutyW-1:0] duty;
      if (period == '0) begin
        pending_duty.push_back('0);
        return;
      end
      err = longint'(tgt) - longint'(meas);
      mag = (err < 0) ? -err : err;
      if (full_err == '0 || mag >= longint'(full_err)) begin
        gain = longint'(max_gain);
      end else begin
        gain = longint'(base_gain)
             + ((longint'(max_gain) - longint'(base_gain)) * mag) / longint'(full_err);
      end
      prop = gain * err;
      step = (longint'(int_gain) * err * longint'(period)) / IncScale;
      trial = integ + step;
      if (trial > IntegHigh) trial = IntegHigh;
      if (trial < IntegLow) trial = IntegLow;
      hi = longint'(duty_high) * DutyScale;
      lo = longint'(duty_low) * DutyScale;
      // Hold the integral when it would push further into a saturated limit.
      sum = prop + trial * 256;
      if (!((sum > hi && err > 0) || (sum < lo && err < 0))) integ = trial;
      sum = prop + integ * 256;
      if (sum > hi) duty = duty_high;
      else if (sum < lo) duty = duty_low;
      else duty = 16'(sum / DutyScale);
      pending_duty.push_back(duty);
    endfunction

    function void check_duty(logic signed [DutyW-1:0] got);
      logic signed [DutyW-1:0] want;
      if (pending_duty.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("duty item %0d arrived with none outstanding", got);
        return;
      end
      want = pending_duty.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("duty mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  pslg_in_if  in_ch ();
  pslg_out_if out_ch ();

  pi_duty_tracker tracker;
  int items_taken = 0;
  int burst_left  = 1;
  int run_left    = 0;
  bit run_neg     = 1'b0;

  pi_speed_loop_dynamic_gain dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Items accepted on either channel, seen with the values from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        tracker.note_item(in_ch.target_speed, in_ch.measured_speed);
        items_taken++;
      end
      if (out_ch.valid && out_ch.ready) tracker.check_duty(out_ch.duty);
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Output pacing: changing stall patterns, and one long hold-off so that the
  // block fills up and stops taking input.
  initial begin : sink_pacing
    int mode;
    int left;
    int hold_left;
    int tick;
    bit held;
    mode = 0;
    left = 0;
    hold_left = 0;
    tick = 0;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(40, 300);
      end
      left--;
      if (!held && items_taken >= 400) begin
        held = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ((tick % 5) != 0);
          default: out_ch.ready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  // Register write: the task returns only after the enable has been sampled low,
  // so the enable is never lowered and raised at the same edge.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  // Offer one speed pair until it is taken, then perhaps pause between bursts.
  task automatic send_item(input logic signed [SpeedW-1:0] tgt,
                           input logic signed [SpeedW-1:0] meas);
    int gap;
    in_ch.valid          <= 1'b1;
    in_ch.target_speed   <= tgt;
    in_ch.measured_speed <= meas;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) == 0) gap = 0;
      else if ($urandom_range(0, 9) == 0) gap = $urandom_range(20, 40);
      else gap = $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Stop offering and wait until every outstanding duty item has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_duty.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [SpeedW-1:0] corner_speed();
    case ($urandom_range(0, 4))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return '0;
      3: return '1;
      default: return 24'h000001;
    endcase
  endfunction

  // Speed pairs: mostly errors around the interpolation range, often in runs of
  // one sign to drive the integral into the limits, plus full-range noise.
  function automatic void pick_speeds(output logic signed [SpeedW-1:0] tgt,
                                      output logic signed [SpeedW-1:0] meas);
    int kind;
    longint span, err, origin;
    bit neg;
    kind = $urandom_range(0, 9);
    if (tracker.full_err == '0) span = 4096;
    else span = longint'(tracker.full_err) * 2 + 2;
    if (span > 4194304) span = 4194304;
    if (run_left == 0) begin
      run_left = $urandom_range(1, 30);
      run_neg = 1'($urandom_range(0, 1));
    end
    run_left--;
    case (kind)
      0, 1: begin
        tgt  = 24'($urandom);
        meas = 24'($urandom);
      end
      8: begin
        meas = 24'($urandom);
        tgt  = meas;
      end
      9: begin
        tgt  = corner_speed();
        meas = corner_speed();
      end
      default: begin
        err = longint'($urandom_range(0, 32'(span)));
        neg = (kind >= 6) ? run_neg : 1'($urandom_range(0, 1));
        if (neg) err = -err;
        origin = longint'($urandom_range(0, 2097152)) - 1048576;
        meas = 24'(origin);
        tgt  = 24'(origin + err);
      end
    endcase
  endfunction

  task automatic random_items(input int count);
    logic signed [SpeedW-1:0] tgt, meas;
    for (int k = 0; k < count; k++) begin
      pick_speeds(tgt, meas);
      send_item(tgt, meas);
    end
  endtask

  // A random register set; unused upper data bits carry noise.
  task automatic random_setup();
    logic [DutyW-1:0] lo, hi, swap;
    logic [FgeW-1:0] fge;
    logic [PerW-1:0] per;
    case ($urandom_range(0, 3))
      0: fge = '0;
      1: fge = 23'($urandom_range(1, 2000));
      2: fge = 23'($urandom_range(1, 65535));
      default: fge = 23'($urandom);
    endcase
    if ($urandom_range(0, 7) == 0) per = '0;
    else if ($urandom_range(0, 1) == 0) per = 16'($urandom_range(1, 2000));
    else per = 16'($urandom);
    lo = 16'($urandom);
    hi = 16'($urandom);
    if ($urandom_range(0, 3) != 0 && $signed(lo) > $signed(hi)) begin
      swap = lo;
      lo = hi;
      hi = swap;
    end
    write_reg(REG_BASE_GAIN, {7'($urandom), 16'($urandom)});
    write_reg(REG_MAX_GAIN, {7'($urandom), 16'($urandom)});
    write_reg(REG_FULL_GAIN_ERROR, fge);
    write_reg(REG_INTEGRAL_GAIN, {7'($urandom), 16'($urandom)});
    write_reg(REG_SAMPLE_PERIOD, {7'($urandom), per});
    write_reg(REG_DUTY_LOW, {7'($urandom), lo});
    write_reg(REG_DUTY_HIGH, {7'($urandom), hi});
  endtask

  // Main sequence.
  initial begin : stimulus
    tracker = new();
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= '0;
    cfg_data_i           <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.target_speed   <= '0;
    in_ch.measured_speed <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: field extremes and errors around the full-gain error.
    send_item(24'sd0, 24'sd0);
    send_item(24'h7FFFFF, 24'h800000);
    send_item(24'h800000, 24'h7FFFFF);
    send_item(24'h7FFFFF, 24'h7FFFFF);
    send_item(24'h800000, 24'h800000);
    send_item(24'sd12800, 24'sd0);
    send_item(24'sd12799, 24'sd0);
    send_item(24'sd0, 24'sd12800);
    send_item(24'sd0, 24'sd12799);
    send_item(24'sd1, 24'sd0);
    send_item(24'sd0, 24'sd1);
    send_item(-24'sd1, 24'sd0);
    send_item(24'sd6400, 24'sd0);
    send_item(24'h800000, 24'sd0);
    send_item(24'sd0, 24'h800000);
    send_item(24'h7FFFFF, 24'sd0);
    send_item(24'h555555, 24'h2AAAAA);
    send_item(24'hAAAAAA, 24'h555555);
    random_items(200);
    drain();

    // Widest settings: gain from zero to full scale over one LSB of error.
    write_reg(REG_BASE_GAIN, 23'h7F0000);
    write_reg(REG_MAX_GAIN, 23'h00FFFF);
    write_reg(REG_FULL_GAIN_ERROR, 23'd1);
    write_reg(REG_INTEGRAL_GAIN, 23'h00FFFF);
    write_reg(REG_SAMPLE_PERIOD, 23'h00FFFF);
    write_reg(REG_DUTY_LOW, {7'h00, 16'h8000});
    write_reg(REG_DUTY_HIGH, {7'h00, 16'h7FFF});
    random_items(200);
    drain();

    // Falling gain, largest full-gain error, no integral action, tight limits.
    write_reg(REG_BASE_GAIN, 23'h00FFFF);
    write_reg(REG_MAX_GAIN, 23'd0);
    write_reg(REG_FULL_GAIN_ERROR, 23'h7FFFFF);
    write_reg(REG_INTEGRAL_GAIN, 23'd0);
    write_reg(REG_SAMPLE_PERIOD, 23'd1);
    write_reg(REG_DUTY_LOW, {7'h00, 16'(-100)});
    write_reg(REG_DUTY_HIGH, {7'h00, 16'(100)});
    random_items(150);
    drain();

    // Zero full-gain error: the maximum gain applies everywhere.
    write_reg(REG_BASE_GAIN, 23'd300);
    write_reg(REG_MAX_GAIN, 23'd40000);
    write_reg(REG_FULL_GAIN_ERROR, 23'd0);
    write_reg(REG_INTEGRAL_GAIN, 23'd5000);
    write_reg(REG_SAMPLE_PERIOD, 23'd3000);
    write_reg(REG_DUTY_LOW, {7'h00, 16'(-2000)});
    write_reg(REG_DUTY_HIGH, {7'h00, 16'(3000)});
    random_items(150);
    drain();

    // Zero period: duty is zero and the integral is left alone.
    write_reg(REG_SAMPLE_PERIOD, 23'd0);
    random_items(50);
    drain();

    // Crossed limits.
    write_reg(REG_BASE_GAIN, 23'd1000);
    write_reg(REG_MAX_GAIN, 23'd20000);
    write_reg(REG_FULL_GAIN_ERROR, 23'd4000);
    write_reg(REG_INTEGRAL_GAIN, 23'd2560);
    write_reg(REG_SAMPLE_PERIOD, 23'd655);
    write_reg(REG_DUTY_LOW, {7'h00, 16'(500)});
    write_reg(REG_DUTY_HIGH, {7'h00, 16'(-500)});
    random_items(150);
    drain();

    // Both limits at zero; a write to the spare index must change nothing.
    write_reg(REG_DUTY_LOW, 23'd0);
    write_reg(REG_DUTY_HIGH, 23'd0);
    write_reg(RegSpare, 23'h7FFFFF);
    random_items(100);
    drain();

    // Random settings.
    repeat (5) begin
      random_setup();
      random_items(80);
      drain();
    end

    repeat (DrainWait) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_duty.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
